/* rtl/core/isort_pkg.sv */
package isort_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned VALUE_W      = 32;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } isort_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      final_res;
    logic                      overflow;
  } isort_out_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic insert;
    logic drain;
  } isort_ctrl_t;

endpackage

/* rtl/core/isort_cell.sv */
module isort_cell
  import isort_pkg::*;
(
  input  logic                      clk,
  input  isort_ctrl_t               ctrl,
  input  logic signed [VALUE_W-1:0] new_value,
  input  logic                      occupied,
  input  logic                      left_gt,
  input  logic signed [VALUE_W-1:0] left_val,
  input  logic signed [VALUE_W-1:0] right_val,
  output logic                      gt,
  output logic signed [VALUE_W-1:0] val
);

  logic signed [VALUE_W-1:0] val_next;

  // strictly greater, so equal values stay in arrival order
  assign gt = occupied && (val > new_value);

  always_comb begin
    val_next = val;
    if (ctrl.drain) begin
      val_next = right_val;
    end else if (ctrl.insert) begin
      if (left_gt) begin
        val_next = left_val;
      end else if (gt || !occupied) begin
        val_next = new_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

/* rtl/core/insertion_sorter_top.sv */
// latency: an item is stored in the cycle it is accepted; after the item marked
//   last, results follow from the next cycle on, one per cycle, one result per stored value
// throughput: one item per cycle while a set fills; busy is high while the chain
//   drains through cell 0, and the receiver cannot stall it
// reset: synchronous, clears fill count, drop flag and drain state; cell values
//   are left as they are, only entries below the count are ever read
module insertion_sorter_top
  import isort_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  isort_in_t  item,
  output logic       strobe,
  output isort_out_t result
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // fill count and drop flag of the set being collected
  logic [CW-1:0] count;
  logic          dropped;
  // drain side
  logic          draining;
  logic [CW-1:0] remaining;
  logic          out_ovf;

  logic        accept;
  logic        full;
  isort_ctrl_t ctrl;

  logic                      gt  [CAPACITY];
  logic signed [VALUE_W-1:0] val [CAPACITY];

  assign accept = start && !busy;
  assign full   = (count == CW'(CAPACITY));
  assign busy   = draining;

  // a value that finds the store full is dropped, the chain holds
  assign ctrl.insert = accept && !full;
  assign ctrl.drain  = draining;

  // chain of compare-and-shift cells, cell 0 holds the smallest value
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                      l_gt;
    logic signed [VALUE_W-1:0] l_val;
    logic signed [VALUE_W-1:0] r_val;

    if (i == 0) begin : g_first
      assign l_gt  = 1'b0;
      assign l_val = val[0];
    end else begin : g_mid
      assign l_gt  = gt[i-1];
      assign l_val = val[i-1];
    end

    // top cell refills with itself while draining, never read again
    if (i == CAPACITY - 1) begin : g_last
      assign r_val = val[i];
    end else begin : g_inner
      assign r_val = val[i+1];
    end

    isort_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .new_value (item.value),
      .occupied  (count > CW'(i)),
      .left_gt   (l_gt),
      .left_val  (l_val),
      .right_val (r_val),
      .gt        (gt[i]),
      .val       (val[i])
    );
  end

  // set bookkeeping and drain sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      dropped   <= 1'b0;
      draining  <= 1'b0;
      remaining <= '0;
      out_ovf   <= 1'b0;
    end else begin
      if (accept) begin
        if (item.last) begin
          // the last item is stored if there is room, then the whole set goes out
          count     <= '0;
          dropped   <= 1'b0;
          draining  <= 1'b1;
          remaining <= full ? count : count + CW'(1);
          out_ovf   <= dropped || full;
        end else if (full) begin
          dropped <= 1'b1;
        end else begin
          count <= count + CW'(1);
        end
      end
      if (draining) begin
        remaining <= remaining - CW'(1);
        if (remaining == CW'(1)) begin
          draining <= 1'b0;
        end
      end
    end
  end

  assign strobe              = draining;
  assign result.sorted_value = val[0];
  assign result.final_res    = draining && (remaining == CW'(1));
  assign result.overflow     = out_ovf;

endmodule

/* rtl/core/isort_checker.sv */
module isort_checker
  import isort_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input isort_in_t  item,
  input logic       strobe,
  input isort_out_t result
);

  // results only come out while the block refuses items
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy)
    else $error("result strobe outside busy window");

  // a set closes with its results starting in the next cycle
  a_last_starts: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.last) |=> strobe)
    else $error("no result after last item");

  // the final result ends the burst
  a_final_ends: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.final_res) |=> !busy)
    else $error("busy after final result");

  // a burst runs without gaps until its final result
  a_burst_gapless: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.final_res) |=> strobe)
    else $error("gap inside result burst");

  // the overflow mark is the same on every result of a set
  a_ovf_steady: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.final_res) |=> $stable(result.overflow))
    else $error("overflow changed inside a set");

endmodule

bind insertion_sorter_top isort_checker u_isort_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .strobe (strobe),
  .result (result)
);

/* verif/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import isort_pkg::*;

  localparam int unsigned CAP        = CAPACITY_DEF;
  localparam int          RAND_ITEMS = 180;
  // cycles with no item accepted and no result before the run is called hung
  localparam int          IDLE_LIMIT = 2000;
  localparam logic signed [VALUE_W-1:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] S_MAX = 32'sh7fff_ffff;

  // one directed row: the item, and where it is obvious, the single result it gives
  typedef struct packed {
    isort_in_t  stim;
    logic       typed;
    isort_out_t want;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic       strobe;
  isort_in_t  item = '0;
  isort_out_t result;

  // shadow copy of the sorted store and its fill state
  logic signed [VALUE_W-1:0] shadow_sorted [CAP];
  int unsigned               shadow_count = 0;
  logic                      shadow_dropped = 1'b0;

  // sorted values still to come out of the block, oldest first
  isort_out_t due_results [$];
  isort_out_t due_head;

  int mismatches = 0;
  int idle_cycles = 0;

  insertion_sorter_top #(
    .CAPACITY(CAP)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .strobe(strobe),
    .result(result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // directed items: single-value sets at the extremes first, then small mixed sets
  stim_row_t dir_rows [22] = '{
    // single-value sets, each result read off directly
    '{'{S_MIN, 1'b1}, 1'b1, '{S_MIN, 1'b1, 1'b0}},
    '{'{S_MAX, 1'b1}, 1'b1, '{S_MAX, 1'b1, 1'b0}},
    '{'{32'sd0, 1'b1}, 1'b1, '{32'sd0, 1'b1, 1'b0}},
    '{'{-32'sd1, 1'b1}, 1'b1, '{-32'sd1, 1'b1, 1'b0}},
    // mixed signs, a repeated value and both extremes
    '{'{32'sd5, 1'b0}, 1'b0, '0},
    '{'{-32'sd3, 1'b0}, 1'b0, '0},
    '{'{32'sd5, 1'b0}, 1'b0, '0},
    '{'{S_MAX, 1'b0}, 1'b0, '0},
    '{'{S_MIN, 1'b0}, 1'b0, '0},
    '{'{32'sd0, 1'b0}, 1'b0, '0},
    '{'{-32'sd1, 1'b1}, 1'b0, '0},
    // descending arrival, every insert shifts the whole store
    '{'{32'sd3, 1'b0}, 1'b0, '0},
    '{'{32'sd2, 1'b0}, 1'b0, '0},
    '{'{32'sd1, 1'b0}, 1'b0, '0},
    '{'{S_MIN, 1'b1}, 1'b0, '0},
    // ascending arrival, no shifts at all
    '{'{S_MIN, 1'b0}, 1'b0, '0},
    '{'{-32'sd1, 1'b0}, 1'b0, '0},
    '{'{32'sd0, 1'b0}, 1'b0, '0},
    '{'{S_MAX, 1'b1}, 1'b0, '0},
    // all equal
    '{'{32'sd7, 1'b0}, 1'b0, '0},
    '{'{32'sd7, 1'b0}, 1'b0, '0},
    '{'{32'sd7, 1'b1}, 1'b0, '0}
  };

  // insert one accepted item into the shadow store; on last, queue the whole set
  function automatic void insert_sorted(isort_in_t it);
    logic signed [VALUE_W-1:0] v;
    int unsigned               p;
    isort_out_t                r;
    v = it.value;
    if (shadow_count >= CAP) begin
      // store full: value is lost, set gets flagged
      shadow_dropped = 1'b1;
    end else begin
      p = shadow_count;
      // strictly greater entries move up, so equal values stay in arrival order
      while (p > 0 && shadow_sorted[p-1] > v) begin
        shadow_sorted[p] = shadow_sorted[p-1];
        p--;
      end
      shadow_sorted[p] = v;
      shadow_count++;
    end
    if (it.last) begin
      for (int k = 0; k < shadow_count; k++) begin
        r.sorted_value = shadow_sorted[k];
        r.final_res    = (k == shadow_count - 1);
        r.overflow     = shadow_dropped;
        due_results.push_back(r);
      end
      shadow_count   = 0;
      shadow_dropped = 1'b0;
    end
  endfunction

  // half full-range values, some near zero to force ties, some extremes
  function automatic logic signed [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0, 1: begin
        case ($urandom_range(0, 5))
          0: return S_MIN;
          1: return S_MAX;
          2: return S_MIN + 1;
          3: return S_MAX - 1;
          4: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      2, 3, 4: return int'($urandom_range(0, 15)) - 8;
      default: return $urandom;
    endcase
  endfunction

  // idle gap before an item: mostly none, some short, a few long
  function automatic int pick_gap(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // present one item and hold it until the block takes it
  task automatic drive_item(input isort_in_t it, input int gap, input bit typed,
                            input isort_out_t want);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    // the item went in at this edge
    if (typed) due_results.push_back(want);
    else insert_sorted(it);
  endtask

  // stop sending until every queued result has come out
  task automatic drain_wait();
    start <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
  endtask

  // result checker: the receiver never stalls, every strobe is a result
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %0d final %0b overflow %0b",
                   result.sorted_value, result.final_res, result.overflow);
      end else begin
        due_head = due_results.pop_front();
        if (result.sorted_value !== due_head.sorted_value ||
            result.final_res !== due_head.final_res ||
            result.overflow !== due_head.overflow) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d/%0b/%0b got %0d/%0b/%0b",
                     due_head.sorted_value, due_head.final_res, due_head.overflow,
                     result.sorted_value, result.final_res, result.overflow);
        end
      end
    end
  end

  // watchdog on cycles with no traffic in either direction
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int        len;
    int        n_sent;
    bit        burst;
    isort_in_t it;

    // hold synchronous reset, then release it
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (dir_rows[i])
      drive_item(dir_rows[i].stim, pick_gap(1'b0), dir_rows[i].typed, dir_rows[i].want);

    // let the store empty out before the capacity sets
    drain_wait();

    // exactly full, one over with the last item dropped, and several over
    for (int j = 0; j < 3; j++) begin
      len = CAP + ((j == 0) ? 0 : (j == 1) ? 1 : 5);
      burst = (j != 1);
      for (int k = 0; k < len; k++) begin
        it.value = rand_value();
        it.last  = (k == len - 1);
        drive_item(it, pick_gap(burst), 1'b0, '0);
      end
    end
    drain_wait();

    // random sets, mostly short, now and then around capacity
    n_sent = 0;
    while (n_sent < RAND_ITEMS) begin
      case ($urandom_range(0, 19))
        0: len = $urandom_range(CAP - 2, CAP + 3);
        1, 2: len = $urandom_range(9, 40);
        default: len = $urandom_range(1, 8);
      endcase
      burst = ($urandom_range(0, 3) == 0);
      // occasional full pause between sets
      if ($urandom_range(0, 9) == 0) drain_wait();
      for (int k = 0; k < len; k++) begin
        it.value = rand_value();
        it.last  = (k == len - 1);
        drive_item(it, pick_gap(burst), 1'b0, '0);
        n_sent++;
      end
    end

    // wait for the last set, then watch a while for stray results
    drain_wait();
    repeat (CAP + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
